@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the core rtl file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPM_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SPM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/spm_pkg.sv @@
// shared constants and types of the sparse polynomial multiplier
// no dependencies
`default_nettype none

package spm_pkg;

   localparam int MAX_TERMS_DEF = 8;
   localparam int EXP_BITS_DEF  = 8;

   localparam int CMD_W     = 2;
   localparam int COEF_W    = 16;
   localparam int IN_EXPO_W = 8;
   localparam int PCOEF_W   = 32;
   localparam int PEXPO_W   = 9;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_FIRST  = 2'd0,
      CMD_LOAD_SECOND = 2'd1,
      CMD_COMPUTE     = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_FEED,
      ST_SETTLE,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

@@ hw/rtl/spm_cell.sv @@
// one cell of the sorting chain: holds a product term, merges equal exponents
// depends on spm_pkg
`default_nettype none

module spm_cell #(
   parameter int SUM_BITS = spm_pkg::EXP_BITS_DEF + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift,
   input  logic                        in_v,
   input  logic [spm_pkg::PCOEF_W-1:0] in_c,
   input  logic [SUM_BITS-1:0]         in_e,
   input  logic                        dn_v,
   input  logic [spm_pkg::PCOEF_W-1:0] dn_c,
   input  logic [SUM_BITS-1:0]         dn_e,
   output logic                        lk_v,
   output logic [spm_pkg::PCOEF_W-1:0] lk_c,
   output logic [SUM_BITS-1:0]         lk_e,
   output logic                        h_v,
   output logic [spm_pkg::PCOEF_W-1:0] h_c,
   output logic [SUM_BITS-1:0]         h_e
);
   import spm_pkg::*;

   logic                h_v_ff, h_v_in;
   logic [PCOEF_W-1:0]  h_c_ff, h_c_in;
   logic [SUM_BITS-1:0] h_e_ff, h_e_in;
   logic                lk_v_ff, lk_v_in;
   logic [PCOEF_W-1:0]  lk_c_ff, lk_c_in;
   logic [SUM_BITS-1:0] lk_e_ff, lk_e_in;

   always_comb begin
      h_v_in  = h_v_ff;
      h_c_in  = h_c_ff;
      h_e_in  = h_e_ff;
      lk_v_in = 1'b0;
      lk_c_in = in_c;
      lk_e_in = in_e;
      if (shift) begin
         // drain: move up one place
         h_v_in = dn_v;
         h_c_in = dn_c;
         h_e_in = dn_e;
      end else if (in_v) begin
         if (!h_v_ff) begin
            h_v_in = 1'b1;
            h_c_in = in_c;
            h_e_in = in_e;
         end else if (in_e == h_e_ff) begin
            h_c_in = h_c_ff + in_c;
         end else if (in_e > h_e_ff) begin
            // take the larger term, push the held one down
            h_c_in  = in_c;
            h_e_in  = in_e;
            lk_v_in = 1'b1;
            lk_c_in = h_c_ff;
            lk_e_in = h_e_ff;
         end else begin
            lk_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_v_ff  <= 1'b0;
         lk_v_ff <= 1'b0;
      end else begin
         h_v_ff  <= h_v_in;
         lk_v_ff <= lk_v_in;
      end
   end

   always_ff @(posedge clock) begin
      h_c_ff  <= h_c_in;
      h_e_ff  <= h_e_in;
      lk_c_ff <= lk_c_in;
      lk_e_ff <= lk_e_in;
   end

   assign h_v  = h_v_ff;
   assign h_c  = h_c_ff;
   assign h_e  = h_e_ff;
   assign lk_v = lk_v_ff;
   assign lk_c = lk_c_ff;
   assign lk_e = lk_e_ff;

endmodule

`default_nettype wire

@@ hw/rtl/spm_chain.sv @@
// row of sorting cells, highest exponent settles at the head
// depends on spm_pkg and spm_cell
`default_nettype none

module spm_chain #(
   parameter int DEPTH    = spm_pkg::MAX_TERMS_DEF * spm_pkg::MAX_TERMS_DEF,
   parameter int SUM_BITS = spm_pkg::EXP_BITS_DEF + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift,
   input  logic                        in_v,
   input  logic [spm_pkg::PCOEF_W-1:0] in_c,
   input  logic [SUM_BITS-1:0]         in_e,
   output logic                        head_v,
   output logic [spm_pkg::PCOEF_W-1:0] head_c,
   output logic [SUM_BITS-1:0]         head_e,
   output logic                        tail_v
);
   import spm_pkg::*;

   // link k feeds cell k, held k+1 feeds cell k on a shift
   logic                lk_v [DEPTH+1];
   logic [PCOEF_W-1:0]  lk_c [DEPTH+1];
   logic [SUM_BITS-1:0] lk_e [DEPTH+1];
   logic                h_v  [DEPTH+1];
   logic [PCOEF_W-1:0]  h_c  [DEPTH+1];
   logic [SUM_BITS-1:0] h_e  [DEPTH+1];

   assign lk_v[0] = in_v;
   assign lk_c[0] = in_c;
   assign lk_e[0] = in_e;

   // nothing below the last cell
   assign h_v[DEPTH] = 1'b0;
   assign h_c[DEPTH] = '0;
   assign h_e[DEPTH] = '0;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      spm_cell #(.SUM_BITS(SUM_BITS)) u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .in_v  (lk_v[k]),
         .in_c  (lk_c[k]),
         .in_e  (lk_e[k]),
         .dn_v  (h_v[k+1]),
         .dn_c  (h_c[k+1]),
         .dn_e  (h_e[k+1]),
         .lk_v  (lk_v[k+1]),
         .lk_c  (lk_c[k+1]),
         .lk_e  (lk_e[k+1]),
         .h_v   (h_v[k]),
         .h_c   (h_c[k]),
         .h_e   (h_e[k])
      );
   end

   assign head_v = h_v[0];
   assign head_c = h_c[0];
   assign head_e = h_e[0];
   assign tail_v = lk_v[DEPTH];

endmodule

`default_nettype wire

@@ hw/rtl/sparse_polynomial_multiply_core.sv @@
// top level of the sparse polynomial multiplier: term stores, pair feed,
// sorting chain and result drain; depends on spm_pkg, spm_chain, assert_macros.svh
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+-----------------------------------
//   req     | in        | req_valid/stall   | req_cmd, req_coef, req_expo
//   rsp     | out       | rsp_valid/stall   | rsp_prod_coef, rsp_prod_expo, rsp_last
//
// loads follow back to back
// a compute beat with both term sets nonempty holds req_stall high while the
//   first*second term pairs are fed, while the cell row settles, and while the row
//   drains its distinct product exponents and the final term
// the length of the cell row (one cell per possible product term) sets the settle time
// reset is synchronous and clears control state only; stores need no clearing pass
// rsp_stall only slows the drain; results wait in an output register
`default_nettype none
`include "assert_macros.svh"

module sparse_polynomial_multiply_core #(
   parameter int MAX_TERMS = spm_pkg::MAX_TERMS_DEF,
   parameter int EXP_BITS  = spm_pkg::EXP_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [spm_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [spm_pkg::COEF_W-1:0]  req_coef,
   input  logic [spm_pkg::IN_EXPO_W-1:0]      req_expo,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [spm_pkg::PCOEF_W-1:0] rsp_prod_coef,
   output logic [spm_pkg::PEXPO_W-1:0]        rsp_prod_expo,
   output logic                               rsp_last
);
   import spm_pkg::*;

   localparam int PROD_DEPTH = MAX_TERMS * MAX_TERMS;
   localparam int SUM_BITS   = EXP_BITS + 1;
   localparam int CNT_BITS   = $clog2(MAX_TERMS + 1);
   localparam int IDX_BITS   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int SETTLE_LEN = PROD_DEPTH + 4;
   localparam int SET_BITS   = $clog2(SETTLE_LEN);
   localparam int IN_PAD_W   = IN_EXPO_W + EXP_BITS;
   localparam int OUT_PAD_W  = SUM_BITS + PEXPO_W;

   // control
   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] first_count_ff, first_count_in;
   logic [CNT_BITS-1:0] second_count_ff, second_count_in;
   logic [IDX_BITS-1:0] i_ff, i_in;
   logic [IDX_BITS-1:0] j_ff, j_in;
   logic [SET_BITS-1:0] settle_ff, settle_in;

   // term stores
   logic signed [COEF_W-1:0] first_coefs_ff  [MAX_TERMS];
   logic [EXP_BITS-1:0]      first_expos_ff  [MAX_TERMS];
   logic signed [COEF_W-1:0] second_coefs_ff [MAX_TERMS];
   logic [EXP_BITS-1:0]      second_expos_ff [MAX_TERMS];

   // feed pipeline
   logic                      rd_v_ff;
   logic signed [COEF_W-1:0]  a_c_ff, b_c_ff;
   logic [EXP_BITS-1:0]       a_e_ff, b_e_ff;
   logic                      mul_v_ff;
   logic signed [PCOEF_W-1:0] mul_c_ff, mul_c_in;
   logic [SUM_BITS-1:0]       mul_e_ff, mul_e_in;

   // drain and output
   logic                pend_v_ff, pend_v_in;
   logic [PCOEF_W-1:0]  pend_c_ff, pend_c_in;
   logic [SUM_BITS-1:0] pend_e_ff, pend_e_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PCOEF_W-1:0]  rsp_c_ff, rsp_c_in;
   logic [PEXPO_W-1:0]  rsp_e_ff, rsp_e_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                req_accept, load_first, load_second;
   logic                issue, i_last, j_last;
   logic                shift, out_free, emit, emit_last, pend_load;
   logic                hd_v, tail_v;
   logic [PCOEF_W-1:0]  hd_c;
   logic [SUM_BITS-1:0] hd_e;
   logic [IN_PAD_W-1:0]  expo_pad;
   logic [EXP_BITS-1:0]  expo_in;
   logic [OUT_PAD_W-1:0] pend_e_pad;

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign load_first = req_accept && (req_cmd == CMD_LOAD_FIRST)
                       && (first_count_ff < CNT_BITS'(MAX_TERMS));
   assign load_second = req_accept && (req_cmd == CMD_LOAD_SECOND)
                        && (second_count_ff < CNT_BITS'(MAX_TERMS));

   // exponent reduced to EXP_BITS, zero-extended when EXP_BITS is wider
   assign expo_pad = {{EXP_BITS{1'b0}}, req_expo};
   assign expo_in  = expo_pad[EXP_BITS-1:0];

   assign i_last   = (CNT_BITS'(i_ff) + CNT_BITS'(1)) == first_count_ff;
   assign j_last   = (CNT_BITS'(j_ff) + CNT_BITS'(1)) == second_count_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer: load, feed pairs, settle the row, drain
   always_comb begin
      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      settle_in       = settle_ff;
      issue           = 1'b0;
      shift           = 1'b0;
      emit            = 1'b0;
      emit_last       = 1'b0;
      pend_load       = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (load_first) begin
               first_count_in = first_count_ff + CNT_BITS'(1);
            end
            if (load_second) begin
               second_count_in = second_count_ff + CNT_BITS'(1);
            end
            if (req_accept && (req_cmd == CMD_COMPUTE)) begin
               if ((first_count_ff != '0) && (second_count_ff != '0)) begin
                  state_in = ST_FEED;
                  i_in     = '0;
                  j_in     = '0;
               end else begin
                  // empty product: no beats, term counts still cleared
                  first_count_in  = '0;
                  second_count_in = '0;
               end
            end
         end
         ST_FEED: begin
            issue = 1'b1;
            if (j_last) begin
               j_in = '0;
               if (i_last) begin
                  state_in        = ST_SETTLE;
                  settle_in       = '0;
                  first_count_in  = '0;
                  second_count_in = '0;
               end else begin
                  i_in = i_ff + IDX_BITS'(1);
               end
            end else begin
               j_in = j_ff + IDX_BITS'(1);
            end
         end
         ST_SETTLE: begin
            if (settle_ff == SET_BITS'(SETTLE_LEN - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               settle_in = settle_ff + SET_BITS'(1);
            end
         end
         ST_DRAIN: begin
            if (hd_v) begin
               if (hd_c == '0) begin
                  // cancelled term, drop it
                  shift = 1'b1;
               end else if (!pend_v_ff) begin
                  shift     = 1'b1;
                  pend_load = 1'b1;
               end else if (out_free) begin
                  // another nonzero term follows, so the pending one is not last
                  shift     = 1'b1;
                  pend_load = 1'b1;
                  emit      = 1'b1;
               end
            end else if (pend_v_ff) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_last = 1'b1;
                  state_in  = ST_LOAD;
               end
            end else begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // pending term and output register
   assign pend_e_pad = {{PEXPO_W{1'b0}}, pend_e_ff};

   always_comb begin
      pend_v_in    = pend_v_ff;
      pend_c_in    = pend_c_ff;
      pend_e_in    = pend_e_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_c_in     = rsp_c_ff;
      rsp_e_in     = rsp_e_ff;
      rsp_last_in  = rsp_last_ff;
      if (pend_load) begin
         pend_v_in = 1'b1;
         pend_c_in = hd_c;
         pend_e_in = hd_e;
      end else if (emit) begin
         pend_v_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_c_in     = pend_c_ff;
         rsp_e_in     = pend_e_pad[PEXPO_W-1:0];
         rsp_last_in  = emit_last;
      end
   end

   // multiply stage: 16 by 16 signed, exponent add
   always_comb begin
      mul_c_in = a_c_ff * b_c_ff;
      mul_e_in = SUM_BITS'(a_e_ff) + SUM_BITS'(b_e_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         i_ff            <= '0;
         j_ff            <= '0;
         settle_ff       <= '0;
         rd_v_ff         <= 1'b0;
         mul_v_ff        <= 1'b0;
         pend_v_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         i_ff            <= i_in;
         j_ff            <= j_in;
         settle_ff       <= settle_in;
         rd_v_ff         <= issue;
         mul_v_ff        <= rd_v_ff;
         pend_v_ff       <= pend_v_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // term stores, written on loads and read one pair per cycle
   always_ff @(posedge clock) begin
      if (load_first) begin
         first_coefs_ff[first_count_ff[IDX_BITS-1:0]] <= req_coef;
         first_expos_ff[first_count_ff[IDX_BITS-1:0]] <= expo_in;
      end
      if (load_second) begin
         second_coefs_ff[second_count_ff[IDX_BITS-1:0]] <= req_coef;
         second_expos_ff[second_count_ff[IDX_BITS-1:0]] <= expo_in;
      end
      a_c_ff <= first_coefs_ff[i_ff];
      a_e_ff <= first_expos_ff[i_ff];
      b_c_ff <= second_coefs_ff[j_ff];
      b_e_ff <= second_expos_ff[j_ff];
   end

   always_ff @(posedge clock) begin
      mul_c_ff    <= mul_c_in;
      mul_e_ff    <= mul_e_in;
      pend_c_ff   <= pend_c_in;
      pend_e_ff   <= pend_e_in;
      rsp_c_ff    <= rsp_c_in;
      rsp_e_ff    <= rsp_e_in;
      rsp_last_ff <= rsp_last_in;
   end

   // one cell per possible product term
   spm_chain #(
      .DEPTH    (PROD_DEPTH),
      .SUM_BITS (SUM_BITS)
   ) u_chain (
      .clock  (clock),
      .reset  (reset),
      .shift  (shift),
      .in_v   (mul_v_ff),
      .in_c   (mul_c_ff),
      .in_e   (mul_e_ff),
      .head_v (hd_v),
      .head_c (hd_c),
      .head_e (hd_e),
      .tail_v (tail_v)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_prod_coef = rsp_c_ff;
   assign rsp_prod_expo = rsp_e_ff;
   assign rsp_last      = rsp_last_ff;

   // checks
   `SPM_ASSERT_IMPLY(a_row_empty_idle, clock, reset, state_ff == ST_LOAD, !hd_v && !pend_v_ff, "cell row not empty between compute beats")
   `SPM_ASSERT_IMPLY(a_no_overflow, clock, reset, 1'b1, !tail_v, "product term fell off the end of the cell row")
   `SPM_ASSERT_IMPLY(a_feed_quiet, clock, reset, state_ff == ST_DRAIN, !rd_v_ff && !mul_v_ff, "feed pipeline still busy during drain")
   `SPM_ASSERT_IMPLY(a_nonzero_beat, clock, reset, rsp_valid, rsp_prod_coef != '0, "zero coefficient on result beat")
   `SPM_ASSERT_NEXT(a_last_ends, clock, reset, emit && emit_last, state_ff == ST_LOAD && !pend_v_ff, "final beat did not end the compute")

endmodule

`default_nettype wire
